@@ hw/rtl/timed_packet_slot_queue_assert.svh @@
// Assertion macros shared by the checker of the timed packet slot queue.
// Depends on nothing; included by the files that carry assertions.
`ifndef TIMED_PACKET_SLOT_QUEUE_ASSERT_SVH
`define TIMED_PACKET_SLOT_QUEUE_ASSERT_SVH

// Property checked outside reset only.
`define TPSQ_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked at every edge, reset included.
`define TPSQ_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hw/rtl/tpsq_pkg.sv @@
// Types and constants of the timed packet slot queue.
// Depends on nothing; imported by every module of the block.
package tpsq_pkg;

    localparam int SLOT_IDX_W = 6;
    localparam int COUNT_W    = 7;
    localparam int CFG_IDX_W  = 2;

    // Command kinds.
    localparam logic [1:0] KIND_ENQUEUE = 2'd0;
    localparam logic [1:0] KIND_RELEASE = 2'd1;
    localparam logic [1:0] KIND_SORT    = 2'd2;

    // Result status codes.
    localparam logic [2:0] STAT_ACCEPTED  = 3'd0;
    localparam logic [2:0] STAT_TOO_EARLY = 3'd1;
    localparam logic [2:0] STAT_TOO_LARGE = 3'd2;
    localparam logic [2:0] STAT_FULL      = 3'd3;
    localparam logic [2:0] STAT_RELEASED  = 3'd4;
    localparam logic [2:0] STAT_NOTHING   = 3'd5;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_STREAM_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TIME_SCALE  = 2'd1;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] seq_id;
        logic [31:0] rtp_stamp;
        logic        is_audio;
        logic [15:0] payload_len;
        logic [31:0] now;
    } in_item_t;

    typedef struct packed {
        logic [2:0]            status;
        logic [SLOT_IDX_W-1:0] slot;
        logic [15:0]           out_seq_id;
        logic                  out_audio;
        logic [15:0]           out_length;
        logic [47:0]           total_bytes;
        logic [COUNT_W-1:0]    queue_len;
        logic                  last;
    } out_item_t;

    // Packet record held per slot.
    typedef struct packed {
        logic [15:0] seq;
        logic [31:0] stamp;
        logic        audio;
        logic [15:0] length;
    } slot_rec_t;

    // One list position: slot index plus a copy of its id for sorting.
    typedef struct packed {
        logic [15:0]           seq;
        logic [SLOT_IDX_W-1:0] slot;
    } ord_entry_t;

    typedef struct packed {
        logic                  wr;
        logic [SLOT_IDX_W-1:0] waddr;
        slot_rec_t             wdata;
        logic [SLOT_IDX_W-1:0] raddr;
    } slot_req_t;

    typedef struct packed {
        logic                  wr;
        logic [SLOT_IDX_W-1:0] waddr;
        ord_entry_t            wdata;
        logic [SLOT_IDX_W-1:0] raddr;
    } ord_req_t;

endpackage

@@ hw/rtl/timed_packet_slot_queue.sv @@
// Timed packet slot queue: top level with configuration registers.
// Depends on tpsq_pkg, tpsq_ctrl, tpsq_slot_mem and tpsq_order_mem.
//
// A command is taken when start is high and busy is low; results come back
// one beat per strobe cycle and cannot be held off by the receiver, so a
// consumer must take every strobe beat. An enqueue passes the multiply,
// admission and check states, then the next-fit search, which steps one slot
// at a time and skips at most SLOTS-1 busy slots. A release walks the list,
// reading the order memory and then the record memory for each packet. A sort
// compares entries one at a time through the single read port of the order
// memory. Busy stays high while the last beat of a command is on strobe.
// Configuration writes are taken only while busy and start are low.
module timed_packet_slot_queue
    import tpsq_pkg::*;
#(
    parameter int SLOTS       = 32,
    parameter int MAX_PAYLOAD = 2048
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  in_item_t             item,
    output logic                 strobe,
    output out_item_t            result,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [19:0]          cfg_data
);

    logic        stream_mode_reg;
    logic [19:0] time_scale_reg;
    slot_req_t   slot_req;
    slot_rec_t   slot_rd;
    ord_req_t    ord_req;
    ord_entry_t  ord_rd;

    // A write never lands together with a command being taken.
    assign cfg_ready = !busy && !start;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stream_mode_reg <= 1'b0;
            time_scale_reg  <= 20'd90000;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_STREAM_MODE: stream_mode_reg <= cfg_data[0];
                CFG_TIME_SCALE:  time_scale_reg  <= cfg_data;
                default:         ;
            endcase
        end
    end

    tpsq_ctrl #(
        .SLOTS       (SLOTS),
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .item        (item),
        .stream_mode (stream_mode_reg),
        .time_scale  (time_scale_reg),
        .busy        (busy),
        .strobe      (strobe),
        .result      (result),
        .slot_req    (slot_req),
        .slot_rd     (slot_rd),
        .ord_req     (ord_req),
        .ord_rd      (ord_rd)
    );

    tpsq_slot_mem #(
        .DEPTH (SLOTS)
    ) u_slot_mem (
        .clk   (clk),
        .req   (slot_req),
        .rdata (slot_rd)
    );

    tpsq_order_mem #(
        .DEPTH (SLOTS)
    ) u_order_mem (
        .clk   (clk),
        .req   (ord_req),
        .rdata (ord_rd)
    );

endmodule

@@ hw/rtl/tpsq_slot_mem.sv @@
// Packet record memory, one entry per slot, registered read.
// Depends on tpsq_pkg.
module tpsq_slot_mem
    import tpsq_pkg::*;
#(
    parameter int DEPTH = 32
)
(
    input  logic      clk,
    input  slot_req_t req,
    output slot_rec_t rdata
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    slot_rec_t mem [DEPTH];
    slot_rec_t rdata_reg;

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (req.wr)
        begin
            mem[req.waddr[AW-1:0]] <= req.wdata;
        end
        rdata_reg <= mem[req.raddr[AW-1:0]];
    end

    assign rdata = rdata_reg;

endmodule

@@ hw/rtl/tpsq_order_mem.sv @@
// List order memory: position i holds the i-th slot of the list and its id.
// Depends on tpsq_pkg.
module tpsq_order_mem
    import tpsq_pkg::*;
#(
    parameter int DEPTH = 32
)
(
    input  logic       clk,
    input  ord_req_t   req,
    output ord_entry_t rdata
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    ord_entry_t mem [DEPTH];
    ord_entry_t rdata_reg;

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (req.wr)
        begin
            mem[req.waddr[AW-1:0]] <= req.wdata;
        end
        rdata_reg <= mem[req.raddr[AW-1:0]];
    end

    assign rdata = rdata_reg;

endmodule

@@ hw/rtl/tpsq_ctrl.sv @@
// Sequencer of the packet slot queue: admission, slot search, release walk
// and selection sort over the two memories. Depends on tpsq_pkg.
module tpsq_ctrl
    import tpsq_pkg::*;
#(
    parameter int SLOTS       = 32,
    parameter int MAX_PAYLOAD = 2048
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  in_item_t    item,
    input  logic        stream_mode,
    input  logic [19:0] time_scale,
    output logic        busy,
    output logic        strobe,
    output out_item_t   result,
    output slot_req_t   slot_req,
    input  slot_rec_t   slot_rd,
    output ord_req_t    ord_req,
    input  ord_entry_t  ord_rd
);

    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_MUL     = 4'd1;
    localparam logic [3:0] ST_ADM     = 4'd2;
    localparam logic [3:0] ST_CHK     = 4'd3;
    localparam logic [3:0] ST_SRCH    = 4'd4;
    localparam logic [3:0] ST_REL_RD  = 4'd5;
    localparam logic [3:0] ST_REL_WT  = 4'd6;
    localparam logic [3:0] ST_REL_CHK = 4'd7;
    localparam logic [3:0] ST_REL_END = 4'd8;
    localparam logic [3:0] ST_SRT_I   = 4'd9;
    localparam logic [3:0] ST_SRT_IW  = 4'd10;
    localparam logic [3:0] ST_SRT_RD  = 4'd11;
    localparam logic [3:0] ST_SRT_CMP = 4'd12;
    localparam logic [3:0] ST_SRT_SW  = 4'd13;
    localparam logic [3:0] ST_SRT_SW2 = 4'd14;

    logic [3:0]            state_reg, state_next;
    logic [COUNT_W-1:0]    held_reg, held_next;
    logic [SLOT_IDX_W-1:0] alloc_reg, alloc_next;
    logic [47:0]           sent_reg, sent_next;
    logic [SLOTS-1:0]      busy_reg, busy_next;
    logic [COUNT_W-1:0]    idx_reg, idx_next;
    logic [COUNT_W-1:0]    keep_reg, keep_next;
    logic [COUNT_W-1:0]    k_reg, k_next;
    logic [COUNT_W-1:0]    n_reg, n_next;
    logic [COUNT_W-1:0]    bidx_reg, bidx_next;
    logic [SLOT_IDX_W-1:0] srch_reg, srch_next;
    logic                  pend_valid_reg, pend_valid_next;
    logic                  strobe_reg, strobe_next;

    in_item_t   item_reg, item_next;
    logic [51:0] prod_reg, prod_next;
    logic [54:0] lhs_reg, lhs_next;
    logic [58:0] rhs_reg, rhs_next;
    ord_entry_t cur_reg, cur_next;
    ord_entry_t best_reg, best_next;
    ord_entry_t cand_reg, cand_next;
    out_item_t  pend_reg, pend_next;
    out_item_t  res_reg, res_next;

    logic [19:0]           scale;
    logic                  rel_ready;
    logic [SLOT_IDX_W-1:0] srch_inc;
    logic [COUNT_W-1:0]    k_inc;

    // Single-beat result with no packet fields.
    function automatic out_item_t mk_res(input logic [2:0] st,
                                         input logic [SLOT_IDX_W-1:0] sl,
                                         input logic [47:0] sent,
                                         input logic [COUNT_W-1:0] ql);
        out_item_t r;
        r             = '0;
        r.status      = st;
        r.slot        = sl;
        r.total_bytes = sent;
        r.queue_len   = ql;
        r.last        = 1'b1;
        return r;
    endfunction

    assign scale     = (time_scale == 20'd0) ? 20'd1 : time_scale;
    assign rel_ready = stream_mode || ({4'd0, slot_rd.stamp, 16'd0} <= prod_reg);
    assign srch_inc  = ({1'b0, srch_reg} + 7'd1 == 7'(SLOTS)) ? '0 : srch_reg + 6'd1;
    assign k_inc     = k_reg + 7'd1;

    // Next-state and datapath logic.
    always_comb
    begin
        state_next      = state_reg;
        held_next       = held_reg;
        alloc_next      = alloc_reg;
        sent_next       = sent_reg;
        busy_next       = busy_reg;
        idx_next        = idx_reg;
        keep_next       = keep_reg;
        k_next          = k_reg;
        n_next          = n_reg;
        bidx_next       = bidx_reg;
        srch_next       = srch_reg;
        pend_valid_next = pend_valid_reg;
        strobe_next     = 1'b0;
        item_next       = item_reg;
        prod_next       = prod_reg;
        lhs_next        = lhs_reg;
        rhs_next        = rhs_reg;
        cur_next        = cur_reg;
        best_next       = best_reg;
        cand_next       = cand_reg;
        pend_next       = pend_reg;
        res_next        = res_reg;
        slot_req        = '0;
        ord_req         = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start && !busy)
                begin
                    item_next  = item;
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                prod_next = 52'(item_reg.now) * 52'(scale);
                case (item_reg.kind)
                    KIND_ENQUEUE:
                    begin
                        state_next = ST_ADM;
                    end
                    KIND_RELEASE:
                    begin
                        idx_next  = '0;
                        keep_next = '0;
                        n_next    = held_reg;
                        if (held_reg == '0)
                        begin
                            res_next    = mk_res(STAT_NOTHING, '0, sent_reg, held_reg);
                            strobe_next = 1'b1;
                            state_next  = ST_IDLE;
                        end
                        else
                        begin
                            state_next = ST_REL_RD;
                        end
                    end
                    KIND_SORT:
                    begin
                        idx_next = '0;
                        n_next   = held_reg;
                        if (held_reg < 7'd2)
                        begin
                            res_next    = mk_res(STAT_NOTHING, '0, sent_reg, held_reg);
                            strobe_next = 1'b1;
                            state_next  = ST_IDLE;
                        end
                        else
                        begin
                            state_next = ST_SRT_I;
                        end
                    end
                    default:
                    begin
                        res_next    = mk_res(STAT_NOTHING, '0, sent_reg, held_reg);
                        strobe_next = 1'b1;
                        state_next  = ST_IDLE;
                    end
                endcase
            end
            ST_ADM:
            begin
                lhs_next   = {39'(item_reg.rtp_stamp) * 39'd99, 16'd0};
                rhs_next   = 59'(prod_reg) * 59'd100;
                state_next = ST_CHK;
            end
            ST_CHK:
            begin
                srch_next = alloc_reg;
                if (!stream_mode && (59'(lhs_reg) > rhs_reg))
                begin
                    res_next    = mk_res(STAT_TOO_EARLY, '0, sent_reg, held_reg);
                    strobe_next = 1'b1;
                    state_next  = ST_IDLE;
                end
                else if (item_reg.payload_len > 16'(MAX_PAYLOAD))
                begin
                    res_next    = mk_res(STAT_TOO_LARGE, '0, sent_reg, held_reg);
                    strobe_next = 1'b1;
                    state_next  = ST_IDLE;
                end
                else if (held_reg == 7'(SLOTS))
                begin
                    res_next    = mk_res(STAT_FULL, '0, sent_reg, held_reg);
                    strobe_next = 1'b1;
                    state_next  = ST_IDLE;
                end
                else
                begin
                    state_next = ST_SRCH;
                end
            end
            ST_SRCH:
            begin
                // Next-fit search; a free slot exists since the list is not full.
                if (!busy_reg[srch_reg[SW-1:0]])
                begin
                    slot_req.wr           = 1'b1;
                    slot_req.waddr        = srch_reg;
                    slot_req.wdata.seq    = item_reg.seq_id;
                    slot_req.wdata.stamp  = item_reg.rtp_stamp;
                    slot_req.wdata.audio  = item_reg.is_audio;
                    slot_req.wdata.length = item_reg.payload_len;
                    ord_req.wr            = 1'b1;
                    ord_req.waddr         = held_reg[SLOT_IDX_W-1:0];
                    ord_req.wdata.seq     = item_reg.seq_id;
                    ord_req.wdata.slot    = srch_reg;
                    busy_next[srch_reg[SW-1:0]] = 1'b1;
                    held_next   = held_reg + 7'd1;
                    alloc_next  = srch_inc;
                    res_next    = mk_res(STAT_ACCEPTED, srch_reg, sent_reg, held_reg + 7'd1);
                    strobe_next = 1'b1;
                    state_next  = ST_IDLE;
                end
                else
                begin
                    srch_next = srch_inc;
                end
            end
            ST_REL_RD:
            begin
                ord_req.raddr = idx_reg[SLOT_IDX_W-1:0];
                state_next    = ST_REL_WT;
            end
            ST_REL_WT:
            begin
                cand_next      = ord_rd;
                slot_req.raddr = ord_rd.slot;
                state_next     = ST_REL_CHK;
            end
            ST_REL_CHK:
            begin
                if (rel_ready)
                begin
                    // Hold this beat back until it is known whether it is the last.
                    sent_next = sent_reg + 48'(slot_rd.length);
                    held_next = held_reg - 7'd1;
                    busy_next[cand_reg.slot[SW-1:0]] = 1'b0;
                    if (pend_valid_reg)
                    begin
                        res_next    = pend_reg;
                        strobe_next = 1'b1;
                    end
                    pend_valid_next       = 1'b1;
                    pend_next.status      = STAT_RELEASED;
                    pend_next.slot        = cand_reg.slot;
                    pend_next.out_seq_id  = slot_rd.seq;
                    pend_next.out_audio   = slot_rd.audio;
                    pend_next.out_length  = slot_rd.length;
                    pend_next.total_bytes = sent_reg + 48'(slot_rd.length);
                    pend_next.queue_len   = held_reg - 7'd1;
                    pend_next.last        = 1'b0;
                end
                else
                begin
                    ord_req.wr    = 1'b1;
                    ord_req.waddr = keep_reg[SLOT_IDX_W-1:0];
                    ord_req.wdata = cand_reg;
                    keep_next     = keep_reg + 7'd1;
                end
                idx_next   = idx_reg + 7'd1;
                state_next = (idx_reg + 7'd1 == n_reg) ? ST_REL_END : ST_REL_RD;
            end
            ST_REL_END:
            begin
                if (pend_valid_reg)
                begin
                    res_next      = pend_reg;
                    res_next.last = 1'b1;
                end
                else
                begin
                    res_next = mk_res(STAT_NOTHING, '0, sent_reg, held_reg);
                end
                pend_valid_next = 1'b0;
                strobe_next     = 1'b1;
                state_next      = ST_IDLE;
            end
            ST_SRT_I:
            begin
                ord_req.raddr = idx_reg[SLOT_IDX_W-1:0];
                state_next    = ST_SRT_IW;
            end
            ST_SRT_IW:
            begin
                cur_next   = ord_rd;
                best_next  = ord_rd;
                bidx_next  = idx_reg;
                k_next     = idx_reg + 7'd1;
                state_next = ST_SRT_RD;
            end
            ST_SRT_RD:
            begin
                ord_req.raddr = k_reg[SLOT_IDX_W-1:0];
                state_next    = ST_SRT_CMP;
            end
            ST_SRT_CMP:
            begin
                // Strictly smaller only, so the first minimum wins.
                if (ord_rd.seq < best_reg.seq)
                begin
                    best_next = ord_rd;
                    bidx_next = k_reg;
                end
                k_next     = k_inc;
                state_next = (k_inc == n_reg) ? ST_SRT_SW : ST_SRT_RD;
            end
            ST_SRT_SW:
            begin
                if (bidx_reg != idx_reg)
                begin
                    ord_req.wr    = 1'b1;
                    ord_req.waddr = idx_reg[SLOT_IDX_W-1:0];
                    ord_req.wdata = best_reg;
                    state_next    = ST_SRT_SW2;
                end
                else
                begin
                    idx_next = idx_reg + 7'd1;
                    if (idx_reg + 7'd2 < n_reg)
                    begin
                        state_next = ST_SRT_I;
                    end
                    else
                    begin
                        res_next    = mk_res(STAT_NOTHING, '0, sent_reg, held_reg);
                        strobe_next = 1'b1;
                        state_next  = ST_IDLE;
                    end
                end
            end
            ST_SRT_SW2:
            begin
                ord_req.wr    = 1'b1;
                ord_req.waddr = bidx_reg[SLOT_IDX_W-1:0];
                ord_req.wdata = cur_reg;
                idx_next      = idx_reg + 7'd1;
                if (idx_reg + 7'd2 < n_reg)
                begin
                    state_next = ST_SRT_I;
                end
                else
                begin
                    res_next    = mk_res(STAT_NOTHING, '0, sent_reg, held_reg);
                    strobe_next = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            held_reg       <= '0;
            alloc_reg      <= '0;
            sent_reg       <= '0;
            busy_reg       <= '0;
            idx_reg        <= '0;
            keep_reg       <= '0;
            k_reg          <= '0;
            n_reg          <= '0;
            bidx_reg       <= '0;
            srch_reg       <= '0;
            pend_valid_reg <= 1'b0;
            strobe_reg     <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            held_reg       <= held_next;
            alloc_reg      <= alloc_next;
            sent_reg       <= sent_next;
            busy_reg       <= busy_next;
            idx_reg        <= idx_next;
            keep_reg       <= keep_next;
            k_reg          <= k_next;
            n_reg          <= n_next;
            bidx_reg       <= bidx_next;
            srch_reg       <= srch_next;
            pend_valid_reg <= pend_valid_next;
            strobe_reg     <= strobe_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        prod_reg <= prod_next;
        lhs_reg  <= lhs_next;
        rhs_reg  <= rhs_next;
        cur_reg  <= cur_next;
        best_reg <= best_next;
        cand_reg <= cand_next;
        pend_reg <= pend_next;
        res_reg  <= res_next;
    end

    assign busy   = (state_reg != ST_IDLE) || strobe_reg;
    assign strobe = strobe_reg;
    assign result = res_reg;

endmodule

@@ hw/rtl/tpsq_checker.sv @@
// Port-level checker for the timed packet slot queue, bound to the top level.
// Depends on tpsq_pkg and timed_packet_slot_queue_assert.svh.
`include "timed_packet_slot_queue_assert.svh"

module tpsq_checker
    import tpsq_pkg::*;
#(
    parameter int SLOTS = 32
)
(
    input logic      clk,
    input logic      rst_n,
    input logic      start,
    input logic      busy,
    input logic      strobe,
    input out_item_t result
);

    // A taken command keeps the block busy until its beats are out.
    `TPSQ_ASSERT(a_accept_busy, clk, rst_n, start && !busy |=> busy, "busy not raised after start")

    // Beats only appear while a command is in progress.
    `TPSQ_ASSERT_ALWAYS(a_strobe_busy, clk, strobe |-> busy, "result beat while not busy")

    // The final beat of a command is not followed by another beat.
    `TPSQ_ASSERT(a_last_gap, clk, rst_n, strobe && result.last |=> !strobe, "beat after last")

    // Only a release produces more than one beat.
    `TPSQ_ASSERT(a_multi_rel, clk, rst_n, strobe && !result.last |-> result.status == STAT_RELEASED, "non-final beat is not a release")

    // The held count never exceeds the pool.
    `TPSQ_ASSERT(a_qlen, clk, rst_n, strobe |-> result.queue_len <= 7'(SLOTS), "queue length above pool size")

endmodule

bind timed_packet_slot_queue tpsq_checker #(
    .SLOTS (SLOTS)
) u_tpsq_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .strobe (strobe),
    .result (result)
);
